### rtl/snell_refraction_vector_unit_macros.svh
// ---------------------------------------------------------------------------
// Assertion macros for the Snell refraction vector unit
// Concurrent checks clocked on clk and disabled while rst_n is low.
// ---------------------------------------------------------------------------
`ifndef SNELL_REFRACTION_VECTOR_UNIT_MACROS_SVH
`define SNELL_REFRACTION_VECTOR_UNIT_MACROS_SVH

// same-cycle implication
`define SRV_ASSERT_IMP(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("srv assertion failed");

// next-cycle implication
`define SRV_ASSERT_NXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("srv assertion failed");

`endif

### rtl/srv_pkg.sv
// ---------------------------------------------------------------------------
// srv_pkg
// Shared constants and types of the Snell refraction vector unit.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

package srv_pkg;

  localparam int COMPONENT_WIDTH_DEF = 18;
  localparam int ETA_W               = 16;
  localparam int ETA_FRAC            = 14;

  typedef struct packed {
    logic adv;
    logic vld;
  } srv_ctl_t;

endpackage

### rtl/srv_sqrt.sv
// ---------------------------------------------------------------------------
// srv_sqrt
// Pipelined restoring square root, one root bit per stage, rounded to the
// nearest integer in a final stage. A side payload travels with each item.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

module srv_sqrt #(
  parameter int N      = srv_pkg::COMPONENT_WIDTH_DEF,
  parameter int SIDE_W = 6 * srv_pkg::COMPONENT_WIDTH_DEF
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  srv_pkg::srv_ctl_t    in_ctl,
  input  logic [2*N-1:0]       in_rad,
  input  logic [SIDE_W-1:0]    in_side,
  output logic                 out_valid,
  output logic [N:0]           out_root,
  output logic [SIDE_W-1:0]    out_side
);

  import srv_pkg::*;

  logic              vld_r   [N];
  logic [N+1:0]      rem_r   [N];
  logic [N-1:0]      root_r  [N];
  logic [2*N-1:0]    rad_r   [N];
  logic [SIDE_W-1:0] side_r  [N];

  logic              vld_i   [N];
  logic [N+1:0]      rem_i   [N];
  logic [N-1:0]      root_i  [N];
  logic [2*N-1:0]    rad_i   [N];
  logic [SIDE_W-1:0] side_i  [N];

  logic [N+1:0]      rem_nxt [N];
  logic [N-1:0]      root_nxt[N];
  logic [2*N-1:0]    rad_nxt [N];

  logic              fin_vld_r;
  logic [N:0]        fin_root_r;
  logic [SIDE_W-1:0] fin_side_r;
  logic [N:0]        fin_root_nxt;

  always_comb begin
    vld_i[0]  = in_ctl.vld;
    rem_i[0]  = '0;
    root_i[0] = '0;
    rad_i[0]  = in_rad;
    side_i[0] = in_side;
    for (int k = 1; k < N; k++) begin
      vld_i[k]  = vld_r[k-1];
      rem_i[k]  = rem_r[k-1];
      root_i[k] = root_r[k-1];
      rad_i[k]  = rad_r[k-1];
      side_i[k] = side_r[k-1];
    end
  end

  always_comb begin
    logic [N+1:0] rem_sh;
    logic [N+1:0] trial;
    rem_sh = '0;
    trial  = '0;
    for (int k = 0; k < N; k++) begin
      rem_sh = {rem_i[k][N-1:0], rad_i[k][2*N-1:2*N-2]};
      trial  = {root_i[k], 2'b01};
      if (rem_sh >= trial) begin
        rem_nxt[k]  = rem_sh - trial;
        root_nxt[k] = {root_i[k][N-2:0], 1'b1};
      end else begin
        rem_nxt[k]  = rem_sh;
        root_nxt[k] = {root_i[k][N-2:0], 1'b0};
      end
      rad_nxt[k] = {rad_i[k][2*N-3:0], 2'b00};
    end
  end

  assign fin_root_nxt = {1'b0, root_r[N-1]}
                      + (N+1)'(rem_r[N-1] > {2'b00, root_r[N-1]});

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int k = 0; k < N; k++) vld_r[k] <= 1'b0;
      fin_vld_r <= 1'b0;
    end else if (in_ctl.adv) begin
      for (int k = 0; k < N; k++) vld_r[k] <= vld_i[k];
      fin_vld_r <= vld_r[N-1];
    end
  end

  always_ff @(posedge clk) begin
    if (in_ctl.adv) begin
      for (int k = 0; k < N; k++) begin
        rem_r[k]  <= rem_nxt[k];
        root_r[k] <= root_nxt[k];
        rad_r[k]  <= rad_nxt[k];
        side_r[k] <= side_i[k];
      end
      fin_root_r <= fin_root_nxt;
      fin_side_r <= side_r[N-1];
    end
  end

  assign out_valid = fin_vld_r;
  assign out_root  = fin_root_r;
  assign out_side  = fin_side_r;

endmodule

### rtl/snell_refraction_vector_unit.sv
// ---------------------------------------------------------------------------
// snell_refraction_vector_unit
// Refracts a unit direction at a surface by Snell's law in signed Q2.F
// fixed point: perp = eta*(d + c*n), par = -sqrt(|1 - |perp|^2|)*n.
//
//  channel | ports                                  | handshake
//  --------+----------------------------------------+------------------
//  in      | in_dir_*, in_normal_*, in_eta_ratio    | in_valid/in_stall
//  out     | out_x, out_y, out_z                    | out_valid/out_stall
//
// One item per cycle while in_stall is low; the path runs through eight
// arithmetic stages, the bit-per-stage square root (W + 1 stages), one
// product stage and the output register.
// Reset clears only the valid bits; there is no clearing pass.
// A two-entry output buffer takes results; the pipeline and in_stall hold
// only while both entries are full.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "snell_refraction_vector_unit_macros.svh"

module snell_refraction_vector_unit #(
  parameter int COMPONENT_WIDTH = srv_pkg::COMPONENT_WIDTH_DEF
) (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              in_valid,
  output logic                              in_stall,
  input  logic signed [COMPONENT_WIDTH-1:0] in_dir_x,
  input  logic signed [COMPONENT_WIDTH-1:0] in_dir_y,
  input  logic signed [COMPONENT_WIDTH-1:0] in_dir_z,
  input  logic signed [COMPONENT_WIDTH-1:0] in_normal_x,
  input  logic signed [COMPONENT_WIDTH-1:0] in_normal_y,
  input  logic signed [COMPONENT_WIDTH-1:0] in_normal_z,
  input  logic [srv_pkg::ETA_W-1:0]         in_eta_ratio,
  output logic                              out_valid,
  input  logic                              out_stall,
  output logic signed [COMPONENT_WIDTH-1:0] out_x,
  output logic signed [COMPONENT_WIDTH-1:0] out_y,
  output logic signed [COMPONENT_WIDTH-1:0] out_z
);

  import srv_pkg::*;

  localparam int W      = COMPONENT_WIDTH;
  localparam int F      = W - 3;
  localparam int PW     = 2 * W;
  localparam int RW     = PW + 1 - F;
  localparam int SW     = RW + 1;
  localparam int EPW    = SW + ETA_W + 1;
  localparam int PRW    = EPW + 1 - ETA_FRAC;
  localparam int QW     = PW + 3;
  localparam int OW     = QW - F;
  localparam int SIDE_W = 6 * W;

  localparam logic [W-1:0] CMIN_W = {1'b1, {(W-1){1'b0}}};
  localparam logic [W-1:0] CMAX_W = {1'b0, {(W-1){1'b1}}};
  localparam logic [W-1:0] ONE_W  = {3'b001, {F{1'b0}}};

  localparam logic signed [PW:0]    HALF_P = {{(PW+1-F){1'b0}}, 1'b1, {(F-1){1'b0}}};
  localparam logic signed [EPW:0]   HALF_E =
    {{(EPW+1-ETA_FRAC){1'b0}}, 1'b1, {(ETA_FRAC-1){1'b0}}};
  localparam logic signed [QW-1:0]  HALF_Q = {{(QW-F){1'b0}}, 1'b1, {(F-1){1'b0}}};

  localparam logic signed [RW+2:0]  CMIN_C = {{(RW+3-W){1'b1}}, CMIN_W};
  localparam logic signed [RW+2:0]  ONE_C  = {{(RW+3-W){1'b0}}, ONE_W};
  localparam logic signed [PRW-1:0] CMIN_P = {{(PRW-W){1'b1}}, CMIN_W};
  localparam logic signed [PRW-1:0] CMAX_P = {{(PRW-W){1'b0}}, CMAX_W};
  localparam logic signed [OW:0]    CMIN_O = {{(OW+1-W){1'b1}}, CMIN_W};
  localparam logic signed [OW:0]    CMAX_O = {{(OW+1-W){1'b0}}, CMAX_W};

  logic adv;
  logic push;

  // stage 1: d*n
  logic                    vld1_r;
  logic signed [W-1:0]     d1_r   [3];
  logic signed [W-1:0]     n1_r   [3];
  logic [ETA_W-1:0]        eta1_r;
  logic signed [PW-1:0]    pdn1_r [3];
  logic signed [W-1:0]     d_in   [3];
  logic signed [W-1:0]     n_in   [3];

  // stage 2: cosine
  logic                    vld2_r;
  logic signed [W-1:0]     d2_r   [3];
  logic signed [W-1:0]     n2_r   [3];
  logic [ETA_W-1:0]        eta2_r;
  logic signed [W-1:0]     c2_r;
  logic signed [W-1:0]     c2_nxt;

  // stage 3: c*n
  logic                    vld3_r;
  logic signed [W-1:0]     d3_r   [3];
  logic signed [W-1:0]     n3_r   [3];
  logic [ETA_W-1:0]        eta3_r;
  logic signed [PW-1:0]    pcn3_r [3];

  // stage 4: d + c*n
  logic                    vld4_r;
  logic signed [W-1:0]     n4_r   [3];
  logic [ETA_W-1:0]        eta4_r;
  logic signed [SW-1:0]    sum4_r [3];
  logic signed [SW-1:0]    sum4_nxt [3];

  // stage 5: eta product
  logic                    vld5_r;
  logic signed [W-1:0]     n5_r   [3];
  logic signed [EPW-1:0]   pe5_r  [3];

  // stage 6: perp
  logic                    vld6_r;
  logic signed [W-1:0]     n6_r   [3];
  logic signed [W-1:0]     perp6_r  [3];
  logic signed [W-1:0]     perp6_nxt[3];

  // stage 7: perp^2
  logic                    vld7_r;
  logic signed [W-1:0]     n7_r   [3];
  logic signed [W-1:0]     perp7_r[3];
  logic signed [PW-1:0]    pp7_r  [3];

  // stage 8: radicand
  logic                    vld8_r;
  logic [2*W-1:0]          rad8_r;
  logic [2*W-1:0]          rad8_nxt;
  logic [SIDE_W-1:0]       side8_r;
  logic [SIDE_W-1:0]       side8_nxt;

  // square root
  srv_ctl_t                sq_ctl;
  logic                    sq_vld;
  logic [W:0]              sq_root;
  logic [SIDE_W-1:0]       sq_side;
  logic signed [W-1:0]     sq_perp[3];
  logic signed [W-1:0]     sq_n   [3];

  // stage 9: s*n
  logic                    vld9_r;
  logic signed [W-1:0]     perp9_r[3];
  logic signed [PW+1:0]    psn9_r [3];
  logic signed [W-1:0]     res_nxt[3];

  // output buffer
  logic                    out_valid_r;
  logic signed [W-1:0]     out_r  [3];
  logic                    skid_valid_r;
  logic signed [W-1:0]     skid_r [3];
  logic                    take;

  logic [8:0]              pipe_vld;

  assign adv      = !(out_valid_r && skid_valid_r);
  assign in_stall = !adv;
  assign push     = adv && vld9_r;
  assign take     = out_valid_r && !out_stall;

  assign d_in[0] = in_dir_x;
  assign d_in[1] = in_dir_y;
  assign d_in[2] = in_dir_z;
  assign n_in[0] = in_normal_x;
  assign n_in[1] = in_normal_y;
  assign n_in[2] = in_normal_z;

  // cosine: round each d*n, sum, negate, limit to [-4, 1]
  always_comb begin
    logic signed [PW:0]   pe;
    logic signed [RW-1:0] r;
    logic signed [RW+1:0] dot;
    logic signed [RW+2:0] negd;
    pe  = '0;
    r   = '0;
    dot = '0;
    for (int i = 0; i < 3; i++) begin
      pe  = $signed({pdn1_r[i][PW-1], pdn1_r[i]}) + HALF_P;
      r   = pe[PW:F];
      dot = dot + $signed({{2{r[RW-1]}}, r});
    end
    negd = -$signed({dot[RW+1], dot});
    if (negd < CMIN_C) begin
      c2_nxt = CMIN_W;
    end else if (negd > ONE_C) begin
      c2_nxt = ONE_W;
    end else begin
      c2_nxt = negd[W-1:0];
    end
  end

  // d + round(c*n)
  always_comb begin
    logic signed [PW:0]   pe;
    logic signed [RW-1:0] r;
    pe = '0;
    r  = '0;
    for (int i = 0; i < 3; i++) begin
      pe          = $signed({pcn3_r[i][PW-1], pcn3_r[i]}) + HALF_P;
      r           = pe[PW:F];
      sum4_nxt[i] = $signed({{(SW-W){d3_r[i][W-1]}}, d3_r[i]}) + $signed({r[RW-1], r});
    end
  end

  // perp = sat(round(eta * sum))
  always_comb begin
    logic signed [EPW:0]   pe;
    logic signed [PRW-1:0] r;
    pe = '0;
    r  = '0;
    for (int i = 0; i < 3; i++) begin
      pe = $signed({pe5_r[i][EPW-1], pe5_r[i]}) + HALF_E;
      r  = pe[EPW:ETA_FRAC];
      if (r < CMIN_P) begin
        perp6_nxt[i] = CMIN_W;
      end else if (r > CMAX_P) begin
        perp6_nxt[i] = CMAX_W;
      end else begin
        perp6_nxt[i] = r[W-1:0];
      end
    end
  end

  // t = |1 - |perp|^2|, radicand t << F
  always_comb begin
    logic signed [PW:0]   pe;
    logic signed [RW-1:0] r;
    logic signed [RW+1:0] lensq;
    logic signed [RW+2:0] t;
    logic signed [RW+2:0] tabs;
    pe    = '0;
    r     = '0;
    lensq = '0;
    for (int i = 0; i < 3; i++) begin
      pe    = $signed({pp7_r[i][PW-1], pp7_r[i]}) + HALF_P;
      r     = pe[PW:F];
      lensq = lensq + $signed({{2{r[RW-1]}}, r});
    end
    t        = ONE_C - $signed({lensq[RW+1], lensq});
    tabs     = t[RW+2] ? -t : t;
    rad8_nxt = {tabs[W+2:0], {F{1'b0}}};
    side8_nxt = {perp7_r[2], perp7_r[1], perp7_r[0], n7_r[2], n7_r[1], n7_r[0]};
  end

  assign sq_ctl.adv = adv;
  assign sq_ctl.vld = vld8_r;

  srv_sqrt #(
    .N      (W),
    .SIDE_W (SIDE_W)
  ) u_sqrt (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_ctl    (sq_ctl),
    .in_rad    (rad8_r),
    .in_side   (side8_r),
    .out_valid (sq_vld),
    .out_root  (sq_root),
    .out_side  (sq_side)
  );

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      sq_n[i]    = sq_side[i*W +: W];
      sq_perp[i] = sq_side[(3+i)*W +: W];
    end
  end

  // out = sat(perp + round(-(s*n)))
  always_comb begin
    logic signed [QW-1:0] q;
    logic signed [OW-1:0] r;
    logic signed [OW:0]   o;
    q = '0;
    r = '0;
    o = '0;
    for (int i = 0; i < 3; i++) begin
      q = -$signed({psn9_r[i][PW+1], psn9_r[i]}) + HALF_Q;
      r = q[QW-1:F];
      o = $signed({{(OW+1-W){perp9_r[i][W-1]}}, perp9_r[i]}) + $signed({r[OW-1], r});
      if (o < CMIN_O) begin
        res_nxt[i] = CMIN_W;
      end else if (o > CMAX_O) begin
        res_nxt[i] = CMAX_W;
      end else begin
        res_nxt[i] = o[W-1:0];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld1_r <= 1'b0;
      vld2_r <= 1'b0;
      vld3_r <= 1'b0;
      vld4_r <= 1'b0;
      vld5_r <= 1'b0;
      vld6_r <= 1'b0;
      vld7_r <= 1'b0;
      vld8_r <= 1'b0;
      vld9_r <= 1'b0;
    end else if (adv) begin
      vld1_r <= in_valid;
      vld2_r <= vld1_r;
      vld3_r <= vld2_r;
      vld4_r <= vld3_r;
      vld5_r <= vld4_r;
      vld6_r <= vld5_r;
      vld7_r <= vld6_r;
      vld8_r <= vld7_r;
      vld9_r <= sq_vld;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      eta1_r <= in_eta_ratio;
      eta2_r <= eta1_r;
      eta3_r <= eta2_r;
      eta4_r <= eta3_r;
      c2_r   <= c2_nxt;
      rad8_r <= rad8_nxt;
      side8_r <= side8_nxt;
      for (int i = 0; i < 3; i++) begin
        d1_r[i]    <= d_in[i];
        n1_r[i]    <= n_in[i];
        pdn1_r[i]  <= d_in[i] * n_in[i];
        d2_r[i]    <= d1_r[i];
        n2_r[i]    <= n1_r[i];
        d3_r[i]    <= d2_r[i];
        n3_r[i]    <= n2_r[i];
        pcn3_r[i]  <= c2_r * n2_r[i];
        n4_r[i]    <= n3_r[i];
        sum4_r[i]  <= sum4_nxt[i];
        n5_r[i]    <= n4_r[i];
        pe5_r[i]   <= $signed({1'b0, eta4_r}) * sum4_r[i];
        n6_r[i]    <= n5_r[i];
        perp6_r[i] <= perp6_nxt[i];
        n7_r[i]    <= n6_r[i];
        perp7_r[i] <= perp6_r[i];
        pp7_r[i]   <= perp6_r[i] * perp6_r[i];
        perp9_r[i] <= sq_perp[i];
        psn9_r[i]  <= $signed({1'b0, sq_root}) * sq_n[i];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r  <= 1'b0;
      skid_valid_r <= 1'b0;
    end else if (!out_valid_r || take) begin
      if (skid_valid_r) begin
        out_valid_r  <= 1'b1;
        skid_valid_r <= push;
      end else begin
        out_valid_r  <= push;
      end
    end else if (push) begin
      skid_valid_r <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    for (int i = 0; i < 3; i++) begin
      if (!out_valid_r || take) begin
        if (skid_valid_r) begin
          out_r[i]  <= skid_r[i];
          skid_r[i] <= res_nxt[i];
        end else begin
          out_r[i]  <= res_nxt[i];
        end
      end else if (push) begin
        skid_r[i] <= res_nxt[i];
      end
    end
  end

  assign out_valid = out_valid_r;
  assign out_x     = out_r[0];
  assign out_y     = out_r[1];
  assign out_z     = out_r[2];

  assign pipe_vld = {vld9_r, vld8_r, vld7_r, vld6_r, vld5_r, vld4_r, vld3_r, vld2_r, vld1_r};

  `SRV_ASSERT_IMP(a_skid_needs_out, skid_valid_r, out_valid_r)
  `SRV_ASSERT_NXT(a_held_push_to_skid, push && out_valid_r && out_stall, skid_valid_r)
  `SRV_ASSERT_NXT(a_stall_freezes_pipe, !adv, $stable(pipe_vld))

endmodule

### sim/testbench.sv
// ---------------------------------------------------------------------------
// Snell refraction vector unit testbench
// Drives incident direction, normal and index ratio items into the unit and
// compares every refracted direction with a fixed-point model of the
// refraction kept in a scoreboard. A short directed set covers the field
// extremes and the clamping and total internal reflection cases. Random
// unit-length rays follow, with some raw bit patterns mixed in. Both sides
// idle and stall at random.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

module testbench;

  localparam int W           = srv_pkg::COMPONENT_WIDTH_DEF;
  localparam int F           = W - 3;
  localparam int EW          = srv_pkg::ETA_W;
  localparam int EF          = srv_pkg::ETA_FRAC;
  localparam longint ONE     = longint'(1) << F;
  localparam longint CMAX    = (longint'(1) << (W - 1)) - 1;
  localparam longint CMIN    = -(longint'(1) << (W - 1));
  localparam int RANDOM_RAYS = 1300;
  localparam int TAIL_CYCLES = 2 * W + 22;
  localparam int CYCLE_LIMIT = 200000;

  typedef logic signed [W-1:0] comp_t;
  typedef struct packed {
    comp_t x;
    comp_t y;
    comp_t z;
  } vec_t;

  class refraction_scoreboard;
    vec_t expected_q[$];
    int unsigned mismatches;

    function new();
      mismatches = 0;
    endfunction

    function longint round_shift(longint v, int s);
      return (v + (longint'(1) << (s - 1))) >>> s;
    endfunction

    function longint clip(longint v, longint lo, longint hi);
      if (v < lo) return lo;
      if (v > hi) return hi;
      return v;
    endfunction

    function longint unsigned round_sqrt(longint unsigned x);
      longint unsigned rem, root, bit_v;
      rem   = x;
      root  = 0;
      bit_v = 64'h1 << 62;
      while (bit_v > x) bit_v = bit_v >> 2;
      while (bit_v != 0) begin
        if (rem >= root + bit_v) begin
          rem  = rem - (root + bit_v);
          root = (root >> 1) + bit_v;
        end else begin
          root = root >> 1;
        end
        bit_v = bit_v >> 2;
      end
      if (rem > root) root = root + 1;
      return root;
    endfunction

    function vec_t refract(vec_t d, vec_t n, logic [EW-1:0] eta);
      longint dv[3], nv[3], perp[3], ov[3];
      longint eta_v, dotv, cosv, lensq, t, sum;
      longint unsigned root;
      vec_t res;
      dv[0] = longint'($signed(d.x));
      dv[1] = longint'($signed(d.y));
      dv[2] = longint'($signed(d.z));
      nv[0] = longint'($signed(n.x));
      nv[1] = longint'($signed(n.y));
      nv[2] = longint'($signed(n.z));
      eta_v = longint'(eta);
      dotv  = 0;
      lensq = 0;
      for (int i = 0; i < 3; i++) dotv += round_shift(dv[i] * nv[i], F);
      cosv = clip(-dotv, CMIN, ONE);
      for (int i = 0; i < 3; i++) begin
        sum     = dv[i] + round_shift(cosv * nv[i], F);
        perp[i] = clip(round_shift(eta_v * sum, EF), CMIN, CMAX);
        lensq  += round_shift(perp[i] * perp[i], F);
      end
      t = ONE - lensq;
      if (t < 0) t = -t;
      root = round_sqrt(longint'(t) << F);
      for (int i = 0; i < 3; i++)
        ov[i] = clip(perp[i] + round_shift(-(longint'(root) * nv[i]), F), CMIN, CMAX);
      res.x = comp_t'(ov[0]);
      res.y = comp_t'(ov[1]);
      res.z = comp_t'(ov[2]);
      return res;
    endfunction

    function void note_input(vec_t d, vec_t n, logic [EW-1:0] eta);
      expected_q.push_back(refract(d, n, eta));
    endfunction

    function int pending();
      return expected_q.size();
    endfunction

    task report(string what, longint got, longint want);
      mismatches++;
      $display("mismatch %s: got %0d, expected %0d", what, got, want);
    endtask

    task check_result(vec_t got);
      vec_t want;
      if (expected_q.size() == 0) begin
        report("result with no item pending, x", longint'($signed(got.x)), 0);
      end else begin
        want = expected_q.pop_front();
        if (got.x !== want.x)
          report("out_x", longint'($signed(got.x)), longint'($signed(want.x)));
        if (got.y !== want.y)
          report("out_y", longint'($signed(got.y)), longint'($signed(want.y)));
        if (got.z !== want.z)
          report("out_z", longint'($signed(got.z)), longint'($signed(want.z)));
      end
    endtask
  endclass

  logic          clk;
  logic          rst_n;
  logic          in_valid;
  logic          in_stall;
  comp_t         in_dir_x, in_dir_y, in_dir_z;
  comp_t         in_normal_x, in_normal_y, in_normal_z;
  logic [EW-1:0] in_eta_ratio;
  logic          out_valid;
  logic          out_stall;
  comp_t         out_x, out_y, out_z;

  refraction_scoreboard sb = new();
  int unsigned accepted_items = 0;
  int unsigned received_items = 0;
  int unsigned cycle_count = 0;
  int in_calm = 0;
  int out_calm = 0;

  snell_refraction_vector_unit uut (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_valid    (in_valid),
    .in_stall    (in_stall),
    .in_dir_x    (in_dir_x),
    .in_dir_y    (in_dir_y),
    .in_dir_z    (in_dir_z),
    .in_normal_x (in_normal_x),
    .in_normal_y (in_normal_y),
    .in_normal_z (in_normal_z),
    .in_eta_ratio(in_eta_ratio),
    .out_valid   (out_valid),
    .out_stall   (out_stall),
    .out_x       (out_x),
    .out_y       (out_y),
    .out_z       (out_z)
  );

  initial clk = 1'b0;
  always #5 clk = ~clk;

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("timeout after %0d cycles", cycle_count);
      $display("testbench failed");
      $finish;
    end
  end

  always @(posedge clk) begin
    if (rst_n && in_valid && !in_stall) begin
      sb.note_input({in_dir_x, in_dir_y, in_dir_z},
                    {in_normal_x, in_normal_y, in_normal_z}, in_eta_ratio);
      accepted_items++;
    end
    if (rst_n && out_valid && !out_stall) begin
      sb.check_result({out_x, out_y, out_z});
      received_items++;
    end
  end

  // idle stretches with no gaps now and then
  function int draw_gap(inout int calm);
    if (calm > 0) begin
      calm--;
      return 0;
    end
    if ($urandom_range(0, 49) == 0) begin
      calm = $urandom_range(10, 40);
      return 0;
    end
    return $urandom_range(0, 14);
  endfunction

  function vec_t mk(longint x, longint y, longint z);
    vec_t v;
    v.x = comp_t'(x);
    v.y = comp_t'(y);
    v.z = comp_t'(z);
    return v;
  endfunction

  // entered and left at a falling edge
  task send_item(input vec_t d, input vec_t n, input logic [EW-1:0] eta);
    int gap;
    int unsigned target;
    gap = draw_gap(in_calm);
    if (gap > 0) begin
      in_valid = 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_dir_x     = d.x;
    in_dir_y     = d.y;
    in_dir_z     = d.z;
    in_normal_x  = n.x;
    in_normal_y  = n.y;
    in_normal_z  = n.z;
    in_eta_ratio = eta;
    in_valid     = 1'b1;
    target = accepted_items + 1;
    do @(negedge clk); while (accepted_items != target);
  endtask

  task random_unit(output vec_t v);
    real a, b, c, len;
    len = 0.0;
    while (len < 0.05) begin
      a = ($itor($urandom_range(0, 65535)) - 32768.0) / 32768.0;
      b = ($itor($urandom_range(0, 65535)) - 32768.0) / 32768.0;
      c = ($itor($urandom_range(0, 65535)) - 32768.0) / 32768.0;
      len = $sqrt(a * a + b * b + c * c);
    end
    v = mk($rtoi(a / len * ONE), $rtoi(b / len * ONE), $rtoi(c / len * ONE));
  endtask

  task directed_items();
    send_item(mk(0, 0, -ONE), mk(0, 0, ONE), 16'd16384);
    send_item(mk(0, 0, -ONE), mk(0, 0, ONE), 16'd0);
    send_item(mk(23170, 0, -23170), mk(0, 0, ONE), 16'd65535);
    send_item(mk(23170, 0, -23170), mk(0, 0, ONE), 16'd10923);
    send_item(mk(23170, 0, -23170), mk(0, 0, ONE), 16'd24576);
    // cosine above one
    send_item(mk(0, 0, -2 * ONE), mk(0, 0, ONE), 16'd16384);
    // cosine below minus four
    send_item(mk(CMAX, CMAX, CMAX), mk(CMAX, CMAX, CMAX), 16'd16384);
    // perpendicular part saturates
    send_item(mk(CMAX, 0, 0), mk(0, 0, CMIN), 16'd65535);
    // output saturates
    send_item(mk(CMIN, CMIN, CMIN), mk(CMIN, CMIN, CMIN), 16'd65535);
    send_item(mk(0, 0, 0), mk(0, 0, 0), 16'd0);
    send_item(mk(CMAX, CMAX, CMAX), mk(CMAX, CMAX, CMAX), 16'hFFFF);
    send_item(mk(CMIN, CMIN, CMIN), mk(CMIN, CMIN, CMIN), 16'd0);
    send_item(mk(CMAX, CMAX, CMAX), mk(CMIN, CMIN, CMIN), 16'd16384);
    send_item(mk(CMIN, CMAX, CMIN), mk(CMAX, CMIN, CMAX), 16'd32768);
    // grazing incidence
    send_item(mk(ONE, 0, -1), mk(0, 0, ONE), 16'd16384);
    send_item(mk(0, ONE, 0), mk(0, -ONE, 0), 16'd16384);
    send_item(mk(3, -3, 5), mk(16384, -16384, 16384), 16'd1);
    // ray leaving along the normal
    send_item(mk(0, 0, ONE), mk(0, 0, ONE), 16'd16384);
    send_item(mk('h2AAAA, 'h2AAAA, 'h2AAAA), mk('h15555, 'h15555, 'h15555), 16'hAAAA);
    send_item(mk('h15555, 'h15555, 'h15555), mk('h2AAAA, 'h2AAAA, 'h2AAAA), 16'h5555);
    send_item(mk(-23170, -23170, 0), mk(0, ONE, 0), 16'd32768);
  endtask

  task random_items();
    vec_t d, n;
    logic [EW-1:0] eta;
    int pick;
    repeat (RANDOM_RAYS) begin
      if ($urandom_range(0, 9) < 7) begin
        random_unit(d);
        random_unit(n);
        if ((longint'($signed(d.x)) * $signed(n.x) + longint'($signed(d.y)) * $signed(n.y)
             + longint'($signed(d.z)) * $signed(n.z)) > 0 && $urandom_range(0, 9) != 0)
          n = mk(-longint'($signed(n.x)), -longint'($signed(n.y)), -longint'($signed(n.z)));
        pick = $urandom_range(0, 9);
        if (pick < 6)      eta = EW'($urandom_range(8192, 32768));
        else if (pick < 8) eta = EW'($urandom_range(15884, 16884));
        else               eta = EW'($urandom_range(0, 65535));
      end else begin
        d.x = comp_t'($urandom);
        d.y = comp_t'($urandom);
        d.z = comp_t'($urandom);
        n.x = comp_t'($urandom);
        n.y = comp_t'($urandom);
        n.z = comp_t'($urandom);
        eta = EW'($urandom);
      end
      send_item(d, n, eta);
    end
  endtask

  initial begin : result_side
    int gap;
    int unsigned seen;
    out_stall = 1'b0;
    forever begin
      gap = draw_gap(out_calm);
      if (gap > 0) begin
        out_stall = 1'b1;
        repeat (gap) @(negedge clk);
      end
      out_stall = 1'b0;
      seen = received_items;
      do @(negedge clk); while (received_items == seen);
    end
  end

  initial begin
    rst_n        = 1'b0;
    in_valid     = 1'b0;
    in_dir_x     = '0;
    in_dir_y     = '0;
    in_dir_z     = '0;
    in_normal_x  = '0;
    in_normal_y  = '0;
    in_normal_z  = '0;
    in_eta_ratio = '0;
    repeat (2) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;
    directed_items();
    random_items();
    in_valid = 1'b0;
    while (sb.pending() != 0) @(negedge clk);
    repeat (TAIL_CYCLES) @(negedge clk);
    if (sb.mismatches == 0 && sb.pending() == 0) begin
      $display("testbench passed");
    end else begin
      $display("testbench failed");
    end
    $finish;
  end

endmodule
